[rtl/cssesc_pkg.sv]
// Shared types, constants and helper functions for the CSS escape decoder.
// No dependencies; every other file in rtl uses this package.
package cssesc_pkg;

   localparam int MAX_HEX_DIGITS_DEFAULT = 6;
   localparam int MAX_RESULTS            = 5;
   localparam int CODE_WIDTH             = 24;
   localparam int COUNT_WIDTH            = 3;

   localparam logic [7:0] BACKSLASH   = 8'h5C;
   localparam logic [CODE_WIDTH-1:0] CODE_LIMIT = 24'h110000;
   localparam logic [CODE_WIDTH-1:0] CODE_4BYTE = 24'h010000;
   localparam logic [CODE_WIDTH-1:0] CODE_3BYTE = 24'h000800;
   localparam logic [CODE_WIDTH-1:0] CODE_2BYTE = 24'h000080;

   localparam logic [7:0] LEAD_2BYTE = 8'hC0;
   localparam logic [7:0] LEAD_3BYTE = 8'hE0;
   localparam logic [7:0] LEAD_4BYTE = 8'hF0;
   localparam logic [7:0] CONT_BYTE  = 8'h80;
   localparam logic [5:0] CONT_MASK  = 6'h3F;

   typedef enum logic [2:0] {
      MODE_PLAIN  = 3'b001,
      MODE_SLASH  = 3'b010,
      MODE_DIGITS = 3'b100
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      mode_type                 mode;
      logic [CODE_WIDTH-1:0]    code_value;
      logic [COUNT_WIDTH-1:0]   digit_count;
   } scan_state_type;

   // Bytes produced by one input item, in order, and how many are meaningful.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [COUNT_WIDTH-1:0]      count;
   } burst_type;

   // Control between the result buffer and the top level.
   typedef struct packed {
      logic can_load;
      logic busy;
   } buf_status_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } utf8_type;

   function automatic hex_type hex_value(input logic [7:0] b);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.value = b[3:0];
      end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
         h.value = b[3:0] + 4'd9;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D || b == 8'h0C;
   endfunction

   function automatic utf8_type encode_utf8(input logic [CODE_WIDTH-1:0] cp);
      utf8_type u;
      u.bytes = '0;
      u.count = 3'd0;
      if (cp < CODE_2BYTE) begin
         u.bytes[0] = cp[7:0];
         u.count    = 3'd1;
      end else if (cp < CODE_3BYTE) begin
         u.bytes[0] = LEAD_2BYTE | {3'b000, cp[10:6]};
         u.bytes[1] = CONT_BYTE  | {2'b00, cp[5:0] & CONT_MASK};
         u.count    = 3'd2;
      end else if (cp < CODE_4BYTE) begin
         u.bytes[0] = LEAD_3BYTE | {4'b0000, cp[15:12]};
         u.bytes[1] = CONT_BYTE  | {2'b00, cp[11:6]};
         u.bytes[2] = CONT_BYTE  | {2'b00, cp[5:0]};
         u.count    = 3'd3;
      end else if (cp < CODE_LIMIT) begin
         u.bytes[0] = LEAD_4BYTE | {5'b00000, cp[20:18]};
         u.bytes[1] = CONT_BYTE  | {2'b00, cp[17:12]};
         u.bytes[2] = CONT_BYTE  | {2'b00, cp[11:6]};
         u.bytes[3] = CONT_BYTE  | {2'b00, cp[5:0]};
         u.count    = 3'd4;
      end
      return u;
   endfunction

endpackage

[rtl/cssesc_decode.sv]
// Combinational escape decoder: scan state plus one input beat gives the next
// state and the burst of output bytes. Depends on cssesc_pkg.
module cssesc_decode #(
   parameter int MAX_HEX_DIGITS = cssesc_pkg::MAX_HEX_DIGITS_DEFAULT
) (
   input  cssesc_pkg::req_type        item,
   input  cssesc_pkg::scan_state_type state_cur,
   output cssesc_pkg::scan_state_type state_nxt,
   output cssesc_pkg::burst_type      burst
);

   cssesc_pkg::hex_type  hex;
   cssesc_pkg::utf8_type code_bytes;
   logic                 emit_slash;
   logic                 emit_code;
   logic                 to_plain;
   logic [2:0]           pre_count;

   assign hex        = cssesc_pkg::hex_value(item.in_byte);
   assign code_bytes = cssesc_pkg::encode_utf8(state_cur.code_value);

   always_comb begin
      state_nxt  = state_cur;
      emit_slash = 1'b0;
      emit_code  = 1'b0;
      to_plain   = 1'b0;
      if (item.end_of_text) begin
         emit_slash  = (state_cur.mode == cssesc_pkg::MODE_SLASH);
         emit_code   = (state_cur.mode == cssesc_pkg::MODE_DIGITS);
         state_nxt.mode        = cssesc_pkg::MODE_PLAIN;
         state_nxt.code_value  = '0;
         state_nxt.digit_count = '0;
      end else begin
         unique case (state_cur.mode)
            cssesc_pkg::MODE_SLASH: begin
               if (hex.valid) begin
                  state_nxt.mode        = cssesc_pkg::MODE_DIGITS;
                  state_nxt.code_value  = {20'd0, hex.value};
                  state_nxt.digit_count = 3'd1;
               end else begin
                  emit_slash = 1'b1;
                  to_plain   = 1'b1;
               end
            end
            cssesc_pkg::MODE_DIGITS: begin
               if (hex.valid && state_cur.digit_count < 3'(MAX_HEX_DIGITS)) begin
                  state_nxt.code_value  = {state_cur.code_value[19:0], hex.value};
                  state_nxt.digit_count = state_cur.digit_count + 3'd1;
               end else begin
                  emit_code             = 1'b1;
                  state_nxt.mode        = cssesc_pkg::MODE_PLAIN;
                  state_nxt.code_value  = '0;
                  state_nxt.digit_count = '0;
                  to_plain              = !cssesc_pkg::is_space(item.in_byte);
               end
            end
            default: begin
               to_plain = 1'b1;
            end
         endcase
      end

      // Plain-text handling of the current byte, after any escape output.
      if (to_plain) begin
         if (item.in_byte == cssesc_pkg::BACKSLASH) begin
            state_nxt.mode        = cssesc_pkg::MODE_SLASH;
            state_nxt.code_value  = '0;
            state_nxt.digit_count = '0;
            to_plain              = 1'b0;
         end else begin
            state_nxt.mode = cssesc_pkg::MODE_PLAIN;
         end
      end

      burst.bytes = '0;
      pre_count   = 3'd0;
      if (emit_slash) begin
         burst.bytes[0] = cssesc_pkg::BACKSLASH;
         pre_count      = 3'd1;
      end else if (emit_code) begin
         burst.bytes[3:0] = code_bytes.bytes;
         pre_count        = code_bytes.count;
      end
      if (to_plain) begin
         burst.bytes[pre_count] = item.in_byte;
      end
      burst.count = pre_count + {2'b00, to_plain};
   end

endmodule

[rtl/cssesc_out_buf.sv]
// Result buffer: holds one burst of up to five bytes and plays it out one beat
// at a time on the result channel. Depends on cssesc_pkg.
module cssesc_out_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  cssesc_pkg::burst_type       burst,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output cssesc_pkg::rsp_type         rsp_data,
   output cssesc_pkg::buf_status_type  status
);

   logic [cssesc_pkg::MAX_RESULTS-1:0][7:0] bytes_ff, bytes_in;
   logic [2:0] count_ff, count_in;
   logic [2:0] pos_ff, pos_in;
   logic       taken;
   logic       final_beat;

   assign rsp_valid  = (pos_ff != count_ff);
   assign taken      = rsp_valid && !rsp_stall;
   assign final_beat = (pos_ff == count_ff - 3'd1);

   assign status.busy     = rsp_valid;
   assign status.can_load = !rsp_valid || (taken && final_beat);

   always_comb begin
      rsp_data.out_byte = 8'd0;
      if (pos_ff < 3'(cssesc_pkg::MAX_RESULTS)) begin
         rsp_data.out_byte = bytes_ff[pos_ff];
      end
      rsp_data.last = final_beat;
   end

   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      if (load) begin
         bytes_in = burst.bytes;
         count_in = burst.count;
         pos_in   = 3'd0;
      end else if (taken) begin
         pos_in = pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      if (reset) begin
         count_ff <= 3'd0;
         pos_ff   <= 3'd0;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

[rtl/css_escape_to_utf8_top.sv]
// Top level of the CSS escape to UTF-8 decoder: scan state registers, the
// decoder and the result buffer. Depends on cssesc_pkg, cssesc_decode, cssesc_out_buf.
//
//   Channel   Direction  Handshake             Beat payload
//   req_      in         req_valid/req_stall   in_byte, end_of_text
//   rsp_      out        rsp_valid/rsp_stall   out_byte, last
//
// Each accepted input beat is decoded in the cycle it is accepted and its
// output bytes (none to five) land in the result buffer at that clock edge.
// The buffer plays out one byte per cycle while rsp_stall is low.
// A new input beat is taken in the same cycle as the final byte of the
// previous burst leaves, or at once when the buffer is empty, so plain text
// runs at one byte per cycle when the result channel does not stall.
// Items with no output bytes leave the buffer empty.
// Reset is synchronous and active high; it returns the scanner to plain text
// and empties the buffer. A stalled result channel holds the current byte and
// stalls the input channel for as long as any byte of the burst is waiting.
module css_escape_to_utf8_top #(
   parameter int MAX_HEX_DIGITS = cssesc_pkg::MAX_HEX_DIGITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cssesc_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cssesc_pkg::rsp_type rsp_data
);

   cssesc_pkg::scan_state_type  state_ff, state_in, state_dec;
   cssesc_pkg::burst_type       burst;
   cssesc_pkg::buf_status_type  buf_status;
   logic                        accept;

   // The input side only waits while earlier bytes still occupy the buffer.
   assign req_stall = !buf_status.can_load;
   assign accept    = req_valid && buf_status.can_load;

   cssesc_decode #(
      .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
   ) u_decode (
      .item      (req_data),
      .state_cur (state_ff),
      .state_nxt (state_dec),
      .burst     (burst)
   );

   cssesc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .burst     (burst),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .status    (buf_status)
   );

   // The scan state only moves on an accepted beat.
   assign state_in = accept ? state_dec : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode        <= cssesc_pkg::MODE_PLAIN;
         state_ff.code_value  <= '0;
         state_ff.digit_count <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
